### design/paging_victim_selector_defines.svh
// Assertion macros shared by the paging victim selector checkers.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef PAGING_VICTIM_SELECTOR_DEFINES_SVH
`define PAGING_VICTIM_SELECTOR_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define PVS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pvs assertion failed");

// Next-cycle implication, masked while in reset.
`define PVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pvs assertion failed");

// Condition that must hold on the first edge after a reset edge.
`define PVS_ASSERT_POST_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) $past(!i_rst_n) |-> (cons)) \
        else $error("pvs assertion failed");

`endif

### design/pvs_pkg.sv
// Shared types and constants for the paging victim selector.
// No dependencies.
`default_nettype none

package pvs_pkg;

    localparam int WORD_W     = 32;  // bitmap word width
    localparam int WORD_LOG   = 5;
    localparam int PAGE_W     = 16;
    localparam int REQ_W      = 3;
    localparam int WRAP_W     = 7;
    localparam int POS_W      = 16;
    localparam int RING_W     = PAGE_W + 1;  // {valid, page}
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [WRAP_W-1:0] WRAP_LIMIT = 7'd123;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2  = 1'd1;

    localparam logic [CFG_DATA_W-1:0] PAGE_COUNT_RST = 17'd65536;
    localparam logic [3:0]            RING_LOG2_RST  = 4'd14;

    localparam logic [REQ_W-1:0] REQ_INIT       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CHOOSE     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PAGED_OUT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PAGED_IN   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PAGED_IN_NR = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DROPPED    = 3'd5;

    typedef struct packed {
        logic                found;
        logic [WORD_LOG-1:0] idx;
    } t_eval;

endpackage

`default_nettype wire

### design/pvs_word_eval.sv
// Finds the lowest free page in one bitmap word (neither protected nor nominated).
// Depends on pvs_pkg.
`default_nettype none

module pvs_word_eval (
    input  logic [pvs_pkg::WORD_W-1:0] i_prot,
    input  logic [pvs_pkg::WORD_W-1:0] i_nom,
    input  logic [pvs_pkg::WORD_W-1:0] i_mask,
    output pvs_pkg::t_eval             o_eval
);
    import pvs_pkg::*;

    logic [WORD_W-1:0] free_bits;

    assign free_bits = ~(i_prot | i_nom) & i_mask;

    // priority: lowest index wins
    always_comb begin
        o_eval = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_eval.found = 1'b1;
                o_eval.idx   = WORD_LOG'(b);
            end
        end
    end

endmodule

`default_nettype wire

### design/paging_victim_selector.sv
// Paging victim selector top level: bitmap memory, ring memory, scan sequencer.
// Depends on pvs_pkg and pvs_word_eval.
//
//  Channel   Dir  Handshake              Payload
//  -------   ---  ---------------------  ---------------------------------------------
//  request   in   i_valid / o_ready      i_req_type, i_page_number
//  result    out  o_valid / i_ready      o_victim_page, o_victim_found,
//                                        o_poll_timeout_request
//  config    in   i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// One transaction at a time. In-range notifications do a memory read-modify-write;
// out-of-range ones and unknown codes are accepted without leaving idle.
// A choose scans one 32-page word per cycle through the bitmap memory read port.
// A round that passes the wrap limit adds a nominated-clear sweep of every bitmap
// word and a second round. Reset and init run a clear sweep over the bitmap and
// ring memories with o_ready low.
// A finished result sits in the output register; further non-choose transactions
// proceed while it waits.
`default_nettype none

module paging_victim_selector #(
    parameter int PAGE_SPACE = 65536,
    parameter int RING_DEPTH = 16384
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pvs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pvs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pvs_pkg::REQ_W-1:0]        i_req_type,
    input  logic [pvs_pkg::PAGE_W-1:0]       i_page_number,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pvs_pkg::PAGE_W-1:0]       o_victim_page,
    output logic                             o_victim_found,
    output logic                             o_poll_timeout_request
);
    import pvs_pkg::*;

    // page quantities: wide enough for PAGE_SPACE itself and for the 17-bit register
    localparam int CW_MIN    = $clog2(PAGE_SPACE + 1);
    localparam int CW        = (CW_MIN > CFG_DATA_W) ? CW_MIN : CFG_DATA_W;
    localparam int NWORDS    = (PAGE_SPACE + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int ST_W      = WA_W + 1;
    localparam int RL_MAXLOG = $clog2(RING_DEPTH + 1) - 1;
    localparam int RS_W      = (RL_MAXLOG > 0) ? RL_MAXLOG : 1;
    localparam int RDEP      = 1 << RS_W;
    localparam int SWEEP_LEN = (NWORDS > RDEP) ? NWORDS : RDEP;
    localparam int SW_W      = $clog2(SWEEP_LEN + 1);
    localparam int RST_PAGES = (PAGE_SPACE < 65536) ? PAGE_SPACE : 65536;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MAP_WR   = 4'd2;
    localparam logic [3:0] S_RING_CHK = 4'd3;
    localparam logic [3:0] S_OLD_WR   = 4'd4;
    localparam logic [3:0] S_NEW_RD   = 4'd5;
    localparam logic [3:0] S_NEW_WR   = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_NOMCLR   = 4'd8;
    localparam logic [3:0] S_RESULT   = 4'd9;

    // bitmap memory word: {nominated, protected}
    logic [2*WORD_W-1:0] map_mem [NWORDS];
    logic [RING_W-1:0]   ring_mem [RDEP];

    logic [2*WORD_W-1:0] r_map_q;
    logic [RING_W-1:0]   r_ring_q;

    logic                map_re, map_we;
    logic [WA_W-1:0]     map_ra, map_wa;
    logic [2*WORD_W-1:0] map_wd;
    logic                ring_re, ring_we;
    logic [RS_W-1:0]     ring_ra, ring_wa;
    logic [RING_W-1:0]   ring_wd;

    logic [3:0]            r_state, n_state;
    logic [CFG_DATA_W-1:0] r_cfg_pages;
    logic [3:0]            r_cfg_rl;
    logic [CW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_start, n_start;
    logic [WRAP_W-1:0]     r_wrap, n_wrap;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [SW_W-1:0]       r_sweep, n_sweep;
    logic [PAGE_W-1:0]     r_req_page, n_req_page;
    logic [PAGE_W-1:0]     r_old_page, n_old_page;
    logic [REQ_W-1:0]      r_op, n_op;
    logic                  r_use_ring, n_use_ring;
    logic [RS_W-1:0]       r_slot, n_slot;
    logic [WA_W-1:0]       r_issue_w, n_issue_w;
    logic [ST_W-1:0]       r_issue_step, n_issue_step;
    logic [WA_W-1:0]       r_eval_w, n_eval_w;
    logic [ST_W-1:0]       r_eval_step, n_eval_step;
    logic                  r_pend, n_pend;
    logic                  r_second, n_second;
    logic                  r_poll, n_poll;
    logic [PAGE_W-1:0]     r_res_page, n_res_page;
    logic                  r_res_found, n_res_found;
    logic                  r_res_poll, n_res_poll;
    logic                  r_ovalid, n_ovalid;
    logic [PAGE_W-1:0]     r_opage, n_opage;
    logic                  r_ofound, n_ofound;
    logic                  r_opoll, n_opoll;

    logic [CW-1:0]     eff_pages;
    logic [CW-1:0]     page_in;
    logic              in_range;
    logic [CW-1:0]     sat_start;
    logic [WA_W-1:0]   last_w;
    logic [ST_W-1:0]   last_step;
    logic [4:0]        rl_eff;
    logic [RS_W-1:0]   ring_mask;
    logic [WORD_W-1:0] lo_mask, ge_mask, gt_mask, last_mask, scan_mask;
    logic [WRAP_W-1:0] wrap_inc;
    logic [CW-1:0]     found_page;
    t_eval             ev;

    function automatic logic [WA_W-1:0] f_word(input logic [PAGE_W-1:0] p);
        logic [CW-1:0] wide;
        wide = CW'(p) >> WORD_LOG;
        return WA_W'(wide);
    endfunction

    function automatic logic [WORD_W-1:0] f_bit(input logic [PAGE_W-1:0] p);
        return WORD_W'(1) << p[WORD_LOG-1:0];
    endfunction

    // zero acts as one page, oversize clamps to PAGE_SPACE
    always_comb begin
        if (r_cfg_pages == '0) begin
            eff_pages = CW'(1);
        end else if (CW'(r_cfg_pages) > CW'(PAGE_SPACE)) begin
            eff_pages = CW'(PAGE_SPACE);
        end else begin
            eff_pages = CW'(r_cfg_pages);
        end
    end

    assign page_in   = CW'(i_page_number);
    assign in_range  = page_in < eff_pages;
    assign sat_start = (r_cursor >= eff_pages) ? eff_pages - CW'(1) : r_cursor;
    assign last_w    = WA_W'((eff_pages - CW'(1)) >> WORD_LOG);
    assign last_step = ST_W'(last_w) + ST_W'(1);

    // ring length clamps to the largest power of two that fits the ring memory
    assign rl_eff    = (5'(r_cfg_rl) > 5'(RL_MAXLOG)) ? 5'(RL_MAXLOG) : 5'(r_cfg_rl);
    assign ring_mask = RS_W'((17'(1) << rl_eff) - 17'(1));

    // masks for the start word of a round and the partial last word
    assign lo_mask   = (WORD_W'(1) << r_start[WORD_LOG-1:0]) - WORD_W'(1);
    assign ge_mask   = ~lo_mask;
    assign gt_mask   = ge_mask & ~(WORD_W'(1) << r_start[WORD_LOG-1:0]);
    assign last_mask = (eff_pages[WORD_LOG-1:0] == '0) ? '1
                     : (WORD_W'(1) << eff_pages[WORD_LOG-1:0]) - WORD_W'(1);

    always_comb begin
        scan_mask = (r_eval_w == last_w) ? last_mask : '1;
        if (r_eval_step == '0) begin
            scan_mask = scan_mask & (r_second ? ge_mask : gt_mask);
        end
        if (r_eval_step == last_step) begin
            scan_mask = scan_mask & lo_mask;
        end
    end

    pvs_word_eval u_eval (
        .i_prot (r_map_q[WORD_W-1:0]),
        .i_nom  (r_map_q[2*WORD_W-1:WORD_W]),
        .i_mask (scan_mask),
        .o_eval (ev)
    );

    assign wrap_inc   = r_wrap + WRAP_W'(1);
    assign found_page = (CW'(r_eval_w) << WORD_LOG) | CW'(ev.idx);

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_start      = r_start;
        n_wrap       = r_wrap;
        n_pos        = r_pos;
        n_sweep      = r_sweep;
        n_req_page   = r_req_page;
        n_old_page   = r_old_page;
        n_op         = r_op;
        n_use_ring   = r_use_ring;
        n_slot       = r_slot;
        n_issue_w    = r_issue_w;
        n_issue_step = r_issue_step;
        n_eval_w     = r_eval_w;
        n_eval_step  = r_eval_step;
        n_pend       = r_pend;
        n_second     = r_second;
        n_poll       = r_poll;
        n_res_page   = r_res_page;
        n_res_found  = r_res_found;
        n_res_poll   = r_res_poll;
        n_ovalid     = r_ovalid & ~i_ready;
        n_opage      = r_opage;
        n_ofound     = r_ofound;
        n_opoll      = r_opoll;
        map_re  = 1'b0;
        map_ra  = '0;
        map_we  = 1'b0;
        map_wa  = '0;
        map_wd  = '0;
        ring_re = 1'b0;
        ring_ra = '0;
        ring_we = 1'b0;
        ring_wa = '0;
        ring_wd = '0;

        case (r_state)
            S_CLEAR: begin
                // page 0 comes out protected, everything else clear
                if (r_sweep < SW_W'(NWORDS)) begin
                    map_we = 1'b1;
                    map_wa = WA_W'(r_sweep);
                    map_wd = {WORD_W'(0), (r_sweep == '0) ? WORD_W'(1) : WORD_W'(0)};
                end
                if (r_sweep < SW_W'(RDEP)) begin
                    ring_we = 1'b1;
                    ring_wa = RS_W'(r_sweep);
                end
                n_sweep = r_sweep + SW_W'(1);
                if (r_sweep == SW_W'(SWEEP_LEN - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req_page = i_page_number;
                    n_op       = i_req_type;
                    case (i_req_type)
                        REQ_INIT: begin
                            n_cursor = eff_pages >> 1;
                            n_wrap   = '0;
                            n_pos    = '0;
                            n_sweep  = '0;
                            n_state  = S_CLEAR;
                        end
                        REQ_CHOOSE: begin
                            n_start      = sat_start;
                            n_cursor     = sat_start;
                            n_issue_w    = WA_W'(sat_start >> WORD_LOG);
                            n_issue_step = '0;
                            n_pend       = 1'b0;
                            n_second     = 1'b0;
                            n_poll       = 1'b0;
                            n_state      = S_SCAN;
                        end
                        REQ_PAGED_OUT, REQ_DROPPED: begin
                            if (in_range) begin
                                map_re  = 1'b1;
                                map_ra  = f_word(i_page_number);
                                n_state = S_MAP_WR;
                            end
                        end
                        REQ_PAGED_IN, REQ_PAGED_IN_NR: begin
                            if (in_range) begin
                                ring_re    = 1'b1;
                                ring_ra    = r_pos[RS_W-1:0] & ring_mask;
                                n_slot     = r_pos[RS_W-1:0] & ring_mask;
                                n_use_ring = (i_req_type == REQ_PAGED_IN);
                                n_state    = S_RING_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MAP_WR: begin
                map_we = 1'b1;
                map_wa = f_word(r_req_page);
                if (r_op == REQ_PAGED_OUT) begin
                    map_wd = {r_map_q[2*WORD_W-1:WORD_W] & ~f_bit(r_req_page),
                              r_map_q[WORD_W-1:0] | f_bit(r_req_page)};
                end else begin
                    map_wd = {r_map_q[2*WORD_W-1:WORD_W],
                              r_map_q[WORD_W-1:0] & ~f_bit(r_req_page)};
                end
                n_state = S_IDLE;
            end
            S_RING_CHK: begin
                // retire the slot's previous page, then refill or invalidate
                ring_we    = 1'b1;
                ring_wa    = r_slot;
                ring_wd    = r_use_ring ? {1'b1, r_req_page} : '0;
                n_pos      = r_pos + POS_W'(1);
                n_old_page = r_ring_q[PAGE_W-1:0];
                if (r_ring_q[PAGE_W]) begin
                    map_re  = 1'b1;
                    map_ra  = f_word(r_ring_q[PAGE_W-1:0]);
                    n_state = S_OLD_WR;
                end else if (!r_use_ring) begin
                    map_re  = 1'b1;
                    map_ra  = f_word(r_req_page);
                    n_state = S_NEW_WR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OLD_WR: begin
                map_we  = 1'b1;
                map_wa  = f_word(r_old_page);
                map_wd  = {r_map_q[2*WORD_W-1:WORD_W],
                           r_map_q[WORD_W-1:0] & ~f_bit(r_old_page)};
                n_state = r_use_ring ? S_IDLE : S_NEW_RD;
            end
            S_NEW_RD: begin
                // separate read so a shared word sees the write just done
                map_re  = 1'b1;
                map_ra  = f_word(r_req_page);
                n_state = S_NEW_WR;
            end
            S_NEW_WR: begin
                map_we  = 1'b1;
                map_wa  = f_word(r_req_page);
                map_wd  = {r_map_q[2*WORD_W-1:WORD_W],
                           r_map_q[WORD_W-1:0] & ~f_bit(r_req_page)};
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // read one word per cycle, evaluate the previous one
                if (r_issue_step <= last_step) begin
                    map_re       = 1'b1;
                    map_ra       = r_issue_w;
                    n_pend       = 1'b1;
                    n_eval_w     = r_issue_w;
                    n_eval_step  = r_issue_step;
                    n_issue_step = r_issue_step + ST_W'(1);
                    n_issue_w    = (r_issue_w == last_w) ? '0 : r_issue_w + WA_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (ev.found) begin
                        map_we      = 1'b1;
                        map_wa      = r_eval_w;
                        map_wd      = {r_map_q[2*WORD_W-1:WORD_W] | (WORD_W'(1) << ev.idx),
                                       r_map_q[WORD_W-1:0]};
                        n_cursor    = found_page;
                        n_res_page  = found_page[PAGE_W-1:0];
                        n_res_found = 1'b1;
                        n_res_poll  = r_poll;
                        n_state     = S_RESULT;
                    end else if (r_eval_step == last_step) begin
                        // scan came back to its start
                        n_poll = 1'b1;
                        if (wrap_inc > WRAP_LIMIT) begin
                            n_wrap  = '0;
                            n_sweep = '0;
                            n_pend  = 1'b0;
                            n_state = S_NOMCLR;
                        end else begin
                            n_wrap      = wrap_inc;
                            n_res_page  = '0;
                            n_res_found = 1'b0;
                            n_res_poll  = 1'b1;
                            n_state     = S_RESULT;
                        end
                    end
                end
            end
            S_NOMCLR: begin
                // pipelined read-modify-write, keeps protect bits
                if (r_sweep < SW_W'(NWORDS)) begin
                    map_re   = 1'b1;
                    map_ra   = WA_W'(r_sweep);
                    n_pend   = 1'b1;
                    n_eval_w = WA_W'(r_sweep);
                    n_sweep  = r_sweep + SW_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    map_we = 1'b1;
                    map_wa = r_eval_w;
                    map_wd = {WORD_W'(0), r_map_q[WORD_W-1:0]};
                end
                if (!r_pend && r_sweep == SW_W'(NWORDS)) begin
                    n_sweep      = '0;
                    n_issue_w    = WA_W'(r_start >> WORD_LOG);
                    n_issue_step = '0;
                    n_second     = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_RESULT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_opage  = r_res_page;
                    n_ofound = r_res_found;
                    n_opoll  = r_res_poll;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= map_mem[map_ra];
        end
        if (ring_we) begin
            ring_mem[ring_wa] <= ring_wd;
        end
        if (ring_re) begin
            r_ring_q <= ring_mem[ring_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg_pages <= PAGE_COUNT_RST;
            r_cfg_rl    <= RING_LOG2_RST;
            r_cursor    <= CW'(RST_PAGES / 2);
            r_wrap      <= '0;
            r_pos       <= '0;
            r_sweep     <= '0;
            r_pend      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_wrap   <= n_wrap;
            r_pos    <= n_pos;
            r_sweep  <= n_sweep;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PAGE_COUNT: r_cfg_pages <= i_cfg_data;
                    CFG_RING_LOG2:  r_cfg_rl    <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_req_page   <= n_req_page;
        r_old_page   <= n_old_page;
        r_op         <= n_op;
        r_use_ring   <= n_use_ring;
        r_slot       <= n_slot;
        r_issue_w    <= n_issue_w;
        r_issue_step <= n_issue_step;
        r_eval_w     <= n_eval_w;
        r_eval_step  <= n_eval_step;
        r_second     <= n_second;
        r_poll       <= n_poll;
        r_res_page   <= n_res_page;
        r_res_found  <= n_res_found;
        r_res_poll   <= n_res_poll;
        r_opage      <= n_opage;
        r_ofound     <= n_ofound;
        r_opoll      <= n_opoll;
    end

    assign o_ready                = (r_state == S_IDLE);
    assign o_valid                = r_ovalid;
    assign o_victim_page          = r_opage;
    assign o_victim_found         = r_ofound;
    assign o_poll_timeout_request = r_opoll;

endmodule

`default_nettype wire

### design/pvs_checker.sv
// Port-level checks for the paging victim selector, bound to its top level.
// Depends on pvs_pkg and paging_victim_selector_defines.svh.
`default_nettype none

`include "paging_victim_selector_defines.svh"

module pvs_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_ready,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic [pvs_pkg::PAGE_W-1:0] o_victim_page,
    input wire logic                       o_victim_found,
    input wire logic                       o_poll_timeout_request
);
    import pvs_pkg::*;

    // a no-space result always reports page zero and asks for a poll timeout
    `PVS_ASSERT_SAME(a_nospace_fmt, o_valid && !o_victim_found, o_victim_page == '0 && o_poll_timeout_request)

    // held result transaction keeps its payload
    `PVS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_victim_page) && $stable(o_victim_found) && $stable(o_poll_timeout_request))

    // reset starts the clear sweep: nothing accepted, nothing pending
    `PVS_ASSERT_POST_RST(a_rst_busy, !o_ready)
    `PVS_ASSERT_POST_RST(a_rst_empty, !o_valid)

endmodule

bind paging_victim_selector pvs_checker u_pvs_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_ready                (o_ready),
    .o_valid                (o_valid),
    .i_ready                (i_ready),
    .o_victim_page          (o_victim_page),
    .o_victim_found         (o_victim_found),
    .o_poll_timeout_request (o_poll_timeout_request)
);

`default_nettype wire

### tb/tb_paging_victim_selector.sv
// Self-checking testbench for paging_victim_selector: directed tests, then random traffic
// with a cycle-accurate-free behavioral predictor of the protect/nominated maps and ring.
// Depends on pvs_pkg and the RTL under design/.
`default_nettype none

module tb_paging_victim_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import pvs_pkg::*;

    // Unknown request codes: accepted, ignored by the block.
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    localparam int  MAX_PG      = 65536;
    localparam int  RING_MAX    = 16384;
    localparam int  HOLD_CYCLES = 300;
    // Overall cycle budget, sized against the init sweeps and full-size choose rounds.
    localparam longint CYCLE_LIMIT = 6_000_000;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              found;
        logic              poll;
    } t_victim;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [REQ_W-1:0]      i_req_type = '0;
    logic [PAGE_W-1:0]     i_page_number = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PAGE_W-1:0]     o_victim_page;
    logic                  o_victim_found;
    logic                  o_poll_timeout_request;

    paging_victim_selector i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_req_type             (i_req_type),
        .i_page_number          (i_page_number),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_victim_page          (o_victim_page),
        .o_victim_found         (o_victim_found),
        .o_poll_timeout_request (o_poll_timeout_request)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the policy state and registers.
    // ------------------------------------------------------------------
    bit [MAX_PG-1:0]   prot_bits;
    bit [MAX_PG-1:0]   nom_bits;
    logic [PAGE_W-1:0] recent_pg [RING_MAX];
    bit                recent_ok [RING_MAX];
    int unsigned       ring_pos;
    int unsigned       cursor;
    int unsigned       wraps;
    int unsigned       reg_pages;
    int unsigned       reg_ring_log2;

    t_victim pending_victims[$];   // expected results, oldest first
    int      nominated_pages[$];   // victims not yet paged out (for sequences)
    int      evicted_pages[$];     // pages paged out, candidates for paged in

    int     errors;
    int     n_sent;
    int     n_choose_seen;
    int     n_found_seen;
    int     n_poll_seen;
    int     n_inits;
    longint cycles;

    bit steady;      // no random idling on either side while set
    bit hold_req;
    logic holding = 1'b0;

    function automatic int unsigned pages_in_use();
        int unsigned p;
        p = reg_pages;
        if (p == 0) p = 1;
        if (p > MAX_PG) p = MAX_PG;
        return p;
    endfunction

    function automatic int unsigned ring_len();
        int unsigned len;
        len = 1 << (reg_ring_log2 & 15);
        while (len > RING_MAX) len = len >> 1;
        return len;
    endfunction

    function automatic void pred_clear_state();
        prot_bits = '0;
        nom_bits  = '0;
        for (int i = 0; i < RING_MAX; i++) begin
            recent_ok[i] = 1'b0;
            recent_pg[i] = '0;
        end
        prot_bits[0] = 1'b1;
        ring_pos = 0;
        wraps    = 0;
        cursor   = pages_in_use() / 2;
    endfunction

    function automatic void policy_paged_in(int unsigned pg, bit keep);
        int unsigned slot;
        slot = ring_pos & (ring_len() - 1);
        // Slot being reused: its old page loses protection.
        if (recent_ok[slot]) prot_bits[recent_pg[slot]] = 1'b0;
        if (keep) begin
            recent_pg[slot] = pg[PAGE_W-1:0];
            recent_ok[slot] = 1'b1;
        end else begin
            prot_bits[pg] = 1'b0;
            recent_ok[slot] = 1'b0;
            recent_pg[slot] = '0;
        end
        ring_pos = (ring_pos + 1) & 16'hFFFF;
    endfunction

    function automatic t_victim policy_choose();
        int unsigned pages;
        int unsigned start;
        int unsigned cur;
        t_victim     v;
        pages = pages_in_use();
        v = '0;
        if (cursor >= pages) cursor = pages - 1;
        start = cursor;
        cur   = cursor;
        forever begin
            cur++;
            if (cur >= pages) cur = 0;
            if (cur == start) begin
                v.poll = 1'b1;
                wraps++;
                if (wraps > WRAP_LIMIT) begin
                    // Too many full rounds: forget nominations, one more round.
                    nom_bits = '0;
                    wraps = 0;
                end else begin
                    cursor = cur;
                    return v;   // no space
                end
            end
            if (!prot_bits[cur] && !nom_bits[cur]) break;
        end
        cursor = cur;
        nom_bits[cur] = 1'b1;
        v.page  = cur[PAGE_W-1:0];
        v.found = 1'b1;
        return v;
    endfunction

    // Apply one accepted transaction; queue the victim it produces, if any.
    function automatic void policy_apply(logic [REQ_W-1:0] kind, logic [PAGE_W-1:0] pg);
        bit      ok;
        t_victim v;
        ok = pg < pages_in_use();
        case (kind)
            REQ_INIT: pred_clear_state();
            REQ_CHOOSE: begin
                v = policy_choose();
                pending_victims.push_back(v);
                if (v.found) nominated_pages.push_back(v.page);
            end
            REQ_PAGED_OUT: if (ok) begin
                prot_bits[pg] = 1'b1;
                nom_bits[pg]  = 1'b0;
            end
            REQ_PAGED_IN:    if (ok) policy_paged_in(pg, 1'b1);
            REQ_PAGED_IN_NR: if (ok) policy_paged_in(pg, 1'b0);
            REQ_DROPPED:     if (ok) prot_bits[pg] = 1'b0;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_victim want;
        if (o_valid && i_ready) begin
            if (pending_victims.size() == 0) begin
                report_mismatch("unexpected result, victim_page", o_victim_page, -1);
            end else begin
                want = pending_victims.pop_front();
                n_choose_seen++;
                if (o_victim_found) n_found_seen++;
                if (o_poll_timeout_request) n_poll_seen++;
                if (o_victim_page !== want.page)
                    report_mismatch("victim_page", o_victim_page, want.page);
                if (o_victim_found !== want.found)
                    report_mismatch("victim_found", o_victim_found, want.found);
                if (o_poll_timeout_request !== want.poll)
                    report_mismatch("poll_timeout_request", o_poll_timeout_request, want.poll);
            end
        end
        if (holding)     i_ready <= 1'b0;
        else if (steady) i_ready <= 1'b1;
        else             i_ready <= ($urandom_range(99) >= 14);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial forever begin
        @(posedge i_clk);
        if (hold_req) begin
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_victims.size());
            $display("paging_victim_selector regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one transaction; returns once it is accepted. Valid stays high
    // afterwards so back-to-back items go out without valid dropping.
    task automatic send_req(logic [REQ_W-1:0] kind, logic [PAGE_W-1:0] pg);
        while (!steady && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= kind;
        i_page_number <= pg;
        do @(posedge i_clk); while (!o_ready);
        policy_apply(kind, pg);
        n_sent++;
        if (kind == REQ_INIT) n_inits++;
    endtask

    // Sender pause: stop offering and wait for every expected result.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_victims.size() != 0) @(posedge i_clk);
    endtask

    // Quiet point for register writes: results drained, trailing notification
    // or init sweep finished (o_ready back high).
    task automatic go_idle();
        drain();
        repeat (8) @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        go_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PAGE_COUNT) reg_pages = value & 32'h1FFFF;
        else                       reg_ring_log2 = value & 32'hF;
    endtask

    task automatic setup(int unsigned pages, int unsigned rlog);
        write_reg(CFG_PAGE_COUNT, pages);
        write_reg(CFG_RING_LOG2, rlog);
        send_req(REQ_INIT, '0);
    endtask

    function automatic logic [PAGE_W-1:0] some_page();
        return PAGE_W'($urandom_range(pages_in_use() - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Registers at reset values: full 65536-page map, cursor at 32768.
    task automatic test_reset_state();
        send_req(REQ_CHOOSE, '0);
        send_req(REQ_CHOOSE, 16'hFFFF);
        send_req(REQ_PAGED_OUT, 16'd32769);
        send_req(REQ_CHOOSE, '0);
    endtask

    // Every request code, page extremes, out-of-range notifications.
    task automatic test_each_request();
        setup(40, 2);
        send_req(REQ_CHOOSE, '0);
        send_req(REQ_PAGED_OUT, 16'd21);
        send_req(REQ_PAGED_IN, 16'd21);
        send_req(REQ_PAGED_IN, 16'd22);
        send_req(REQ_PAGED_IN_NR, 16'd23);
        send_req(REQ_DROPPED, 16'd0);           // page 0 loses protection
        send_req(REQ_PAGED_OUT, 16'hFFFF);      // out of range: ignored
        send_req(REQ_PAGED_IN, 16'd40);         // out of range: ring stays put
        send_req(REQ_RSVD6, 16'd5);
        send_req(REQ_RSVD7, 16'hAAAA);
        send_req(REQ_PAGED_IN, 16'd24);
        send_req(REQ_PAGED_IN, 16'd25);
        send_req(REQ_PAGED_IN, 16'd26);         // reuses slot: 22 unprotected
        send_req(REQ_CHOOSE, 16'h5555);
        send_req(REQ_CHOOSE, '0);
        send_req(REQ_INIT, 16'hFFFF);
        send_req(REQ_CHOOSE, '0);
    endtask

    // Page count lowered after init leaves the cursor past the end.
    task automatic test_cursor_clamp();
        setup(1000, 14);
        write_reg(CFG_PAGE_COUNT, 100);         // cursor 500 >= 100
        send_req(REQ_CHOOSE, '0);
        send_req(REQ_CHOOSE, '0);
        write_reg(CFG_PAGE_COUNT, 0);           // acts as one page
        send_req(REQ_CHOOSE, '0);
        send_req(REQ_PAGED_IN, 16'd0);
    endtask

    // One page only: every choose is a no-space wrap. Then four pages: past the wrap
    // limit the nominated map is cleared and the scan retried.
    task automatic test_wrap_limit();
        setup(1, 0);
        repeat (10) send_req(REQ_CHOOSE, '0);
        setup(4, 1);
        repeat (WRAP_LIMIT + 8) send_req(REQ_CHOOSE, '0);
        send_req(REQ_PAGED_OUT, 16'd3);
        repeat (WRAP_LIMIT + 4) send_req(REQ_CHOOSE, '0);
    endtask

    // Register extremes: page count above the map size, ring log2 above depth.
    task automatic test_register_extremes();
        setup(17'h1FFFF, 15);
        send_req(REQ_PAGED_IN, 16'hFFFF);
        send_req(REQ_CHOOSE, '0);
        send_req(REQ_DROPPED, 16'hFFFF);
        send_req(REQ_CHOOSE, '0);
        setup(64, 0);
        for (int i = 1; i < 6; i++) send_req(REQ_PAGED_IN, PAGE_W'(i));
        repeat (3) send_req(REQ_CHOOSE, '0);
    endtask

    // Receiver holds off while the sender keeps offering, then a full pause.
    task automatic test_backpressure();
        setup(200, 3);
        steady = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_req(REQ_CHOOSE, '0);
            send_req(REQ_PAGED_IN, some_page());
        end
        steady = 1'b0;
        drain();
        repeat (5) send_req(REQ_CHOOSE, '0);
    endtask

    // Mostly well-formed life cycles: choose, page out the victim, page it
    // back in, drop it; plus noise across the whole field range.
    task automatic random_burst(int count);
        int unsigned r;
        int          pg;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(999);
            if (r < 300) begin
                send_req(REQ_CHOOSE, PAGE_W'($urandom));
            end else if (r < 450) begin
                if (nominated_pages.size() != 0) pg = nominated_pages.pop_front();
                else pg = some_page();
                send_req(REQ_PAGED_OUT, PAGE_W'(pg));
                evicted_pages.push_back(pg);
            end else if (r < 600) begin
                if (evicted_pages.size() != 0) pg = evicted_pages.pop_front();
                else pg = some_page();
                send_req(REQ_PAGED_IN, PAGE_W'(pg));
            end else if (r < 680) begin
                send_req(REQ_PAGED_IN_NR, some_page());
            end else if (r < 760) begin
                send_req(REQ_DROPPED, some_page());
            end else if (r < 997) begin
                send_req(REQ_W'($urandom_range(7, 1)), PAGE_W'($urandom));
            end else begin
                send_req(REQ_INIT, PAGE_W'($urandom));
            end
        end
    endtask

    task automatic test_random();
        int unsigned pages;
        for (int ph = 0; ph < 6; ph++) begin
            pages = (ph == 5) ? 3000 : $urandom_range(300, 1);
            setup(pages, $urandom_range(15));
            nominated_pages.delete();
            evicted_pages.delete();
            steady = (ph == 2);   // one phase with no idling at all
            random_burst(ph == 5 ? 40 : 100);
        end
        steady = 1'b0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        reg_pages = PAGE_COUNT_RST;
        reg_ring_log2 = RING_LOG2_RST;
        pred_clear_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_each_request();
        test_cursor_clamp();
        test_wrap_limit();
        test_register_extremes();
        test_backpressure();
        test_random();

        drain();
        repeat (40) @(posedge i_clk);
        if (pending_victims.size() != 0)
            report_mismatch("results never delivered", 0, pending_victims.size());

        $display("covered %0d transactions (%0d inits), %0d victim results:",
                 n_sent, n_inits, n_choose_seen);
        $display("  %0d found, %0d poll; %0d cycles, %0d mismatches",
                 n_found_seen, n_poll_seen, cycles, errors);
        if (errors == 0) begin
            $display("paging_victim_selector regression: pass");
        end else begin
            $display("paging_victim_selector regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/pvs_pkg.sv
design/pvs_word_eval.sv
design/paging_victim_selector.sv
design/pvs_checker.sv
tb/tb_paging_victim_selector.sv
